[rtl/spd_pkg.sv]
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the sequence pair distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SITES = 2'd1,
    ST_UNDEF    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_DNA_MODE = 2'd0,
    CFG_KIMURA   = 2'd1,
    CFG_TOSS_GAP = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_CHK,
    S_PMUL,
    S_PCHK,
    S_LOG,
    S_GAP,
    S_LN,
    S_LNFIN,
    S_DONE
  } back_state_e;

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_SQ,
    L_STEP
  } log_state_e;

  typedef struct packed {
    logic dna_mode;
    logic kimura_correct;
  } mode_t;

  localparam int unsigned RES_W    = 5;
  localparam int unsigned DIST_W   = 20;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned SITES_W  = 17;
  localparam int unsigned QUO_W    = 18;
  localparam int unsigned LOG_FRAC = 40;
  localparam int unsigned LOG_INT  = 6;
  localparam int unsigned LOG_W    = LOG_INT + LOG_FRAC;
  localparam int unsigned L2_W     = LOG_W + 2;

  localparam logic [DIST_W-1:0]  DIST_MAX      = 20'hFFFFF;
  localparam logic [SITES_W-1:0] SITES_OUT_MAX = 17'h1FFFF;
  localparam logic [63:0]        LN2_Q64       = 64'hB17217F7D1CF79AB;

  localparam logic [RES_W-1:0] RES_GAP = 5'd0;
  localparam logic [RES_W-1:0] RES_A   = 5'd1;
  localparam logic [RES_W-1:0] RES_C   = 5'd2;
  localparam logic [RES_W-1:0] RES_G   = 5'd3;
  localparam logic [RES_W-1:0] RES_T   = 5'd4;

  function automatic logic is_transition(input logic [RES_W-1:0] a, input logic [RES_W-1:0] b);
    return ((a == RES_A) && (b == RES_G)) || ((a == RES_G) && (b == RES_A)) ||
           ((a == RES_C) && (b == RES_T)) || ((a == RES_T) && (b == RES_C));
  endfunction

endpackage

`default_nettype wire

[rtl/spd_front.sv]
// ----------------------------------------------------------------------------
// spd_front
// Column classifier: holds configuration, counts sites, transitions and
// transversions (outside DNA mode, all differences as transitions), and hands one job per sequence pair to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_front #(
  parameter int unsigned MAX_SITES = 65536,
  parameter int unsigned CW        = 17
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  input  wire logic [1:0]               cfg_addr_i,
  input  wire logic                     cfg_data_i,
  input  wire logic                     col_valid_i,
  output logic                          col_ready_o,
  input  wire logic [spd_pkg::RES_W-1:0] res_a_i,
  input  wire logic [spd_pkg::RES_W-1:0] res_b_i,
  input  wire logic                     gap_column_i,
  input  wire logic                     last_i,
  output logic                          push_o,
  input  wire logic                     push_ready_i,
  output logic [CW-1:0]                 sites_o,
  output logic [CW-1:0]                 ts_o,
  output logic [CW-1:0]                 tv_o,
  output spd_pkg::mode_t                mode_o
);
  import spd_pkg::*;

  logic          dna_q, kc_q, toss_q;
  logic [CW-1:0] site_q, site_d, ts_q, ts_d, tv_q, tv_d;
  logic          accept, skip, count_en, diff, ts_hit;

  assign col_ready_o = push_ready_i;
  assign accept      = col_valid_i && col_ready_o;
  assign skip        = (res_a_i == RES_GAP) || (res_b_i == RES_GAP) ||
                       (toss_q && gap_column_i);
  assign count_en    = accept && !skip && (site_q < CW'(MAX_SITES));
  assign diff        = res_a_i != res_b_i;
  assign ts_hit      = dna_q && is_transition(res_a_i, res_b_i);

  always_comb begin
    site_d = site_q + CW'(count_en);
    ts_d   = ts_q + CW'(count_en && diff && (!dna_q || ts_hit));
    tv_d   = tv_q + CW'(count_en && diff && dna_q && !ts_hit);
  end

  assign push_o  = accept && last_i;
  assign sites_o = site_d;
  assign ts_o    = ts_d;
  assign tv_o    = tv_d;
  assign mode_o  = '{dna_mode: dna_q, kimura_correct: kc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dna_q  <= 1'b1;
      kc_q   <= 1'b0;
      toss_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_DNA_MODE: dna_q  <= cfg_data_i;
        CFG_KIMURA:   kc_q   <= cfg_data_i;
        CFG_TOSS_GAP: toss_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_q <= '0;
      ts_q   <= '0;
      tv_q   <= '0;
    end else if (accept) begin
      if (last_i) begin
        site_q <= '0;
        ts_q   <= '0;
        tv_q   <= '0;
      end else begin
        site_q <= site_d;
        ts_q   <= ts_d;
        tv_q   <= tv_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/spd_fifo.sv]
// ----------------------------------------------------------------------------
// spd_fifo
// Two-entry job queue between the column front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_fifo #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  output logic              push_ready_o,
  input  wire logic [W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      pop_data_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

[rtl/spd_div.sv]
// ----------------------------------------------------------------------------
// spd_div
// Restoring divider, one quotient bit a cycle: round(num * 65536 / den).
// ----------------------------------------------------------------------------
`default_nettype none

module spd_div #(
  parameter int unsigned CW = 17
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [CW-1:0]             num_i,
  input  wire logic [CW-1:0]             den_i,
  output logic                           done_o,
  output logic [spd_pkg::QUO_W-1:0]      quo_o
);
  import spd_pkg::*;

  localparam int unsigned NW = CW + QUO_W;

  logic [NW-1:0]    rem_q, dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q, fit;

  assign fit    = rem_q >= dsh_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= (NW'(num_i) << (QUO_W - 1)) + NW'(den_i);
      dsh_q <= NW'(den_i) << QUO_W;
      quo_q <= '0;
    end else if (busy_q) begin
      if (fit) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QUO_W-2:0], fit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QUO_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/spd_log2.sv]
// ----------------------------------------------------------------------------
// spd_log2
// Base-2 logarithm by repeated squaring: six integer and forty fraction bits,
// truncated. Each squaring takes three partial products of a shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_log2 #(
  parameter int unsigned XW = 37
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [XW-1:0]             x_i,
  output logic                           done_o,
  output logic [spd_pkg::LOG_W-1:0]      log_o
);
  import spd_pkg::*;

  log_state_e            state_q, state_d;
  logic [62:0]           m_q;
  logic [5:0]            n_q;
  logic [LOG_FRAC-1:0]   frac_q;
  logic [5:0]            it_q;
  logic [1:0]            k_q;
  logic [63:0]           prod_q, prod_d;
  logic [125:0]          acc_q;
  logic [63:0]           t;
  logic [31:0]           al, ah;
  logic                  done_q;

  assign al     = m_q[31:0];
  assign ah     = {1'b0, m_q[62:32]};
  assign t      = acc_q[125:62];
  assign done_o = done_q;
  assign log_o  = {n_q, frac_q};

  always_comb begin
    state_d = state_q;
    prod_d  = al * al;
    case (state_q)
      L_IDLE: if (start_i) state_d = (x_i == '0) ? L_IDLE : L_NORM;
      L_NORM: if (m_q[62]) state_d = L_SQ;
      L_SQ: begin
        case (k_q)
          2'd1:    prod_d = al * ah;
          2'd2:    prod_d = ah * ah;
          default: prod_d = al * al;
        endcase
        if (k_q == 2'd3) state_d = L_STEP;
      end
      L_STEP: state_d = (it_q == 6'(LOG_FRAC - 1)) ? L_IDLE : L_SQ;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: if (start_i) begin
        m_q    <= 63'(x_i) << (62 - (XW - 1));
        n_q    <= (x_i == '0) ? '0 : 6'(XW - 1);
        frac_q <= '0;
        it_q   <= '0;
      end
      L_NORM: begin
        k_q   <= '0;
        acc_q <= '0;
        if (!m_q[62]) begin
          m_q <= {m_q[61:0], 1'b0};
          n_q <= n_q - 6'd1;
        end
      end
      L_SQ: begin
        prod_q <= prod_d;
        k_q    <= k_q + 2'd1;
        case (k_q)
          2'd1:    acc_q <= acc_q + 126'(prod_q);
          2'd2:    acc_q <= acc_q + (126'(prod_q) << 33);
          2'd3:    acc_q <= acc_q + (126'(prod_q) << 64);
          default: ;
        endcase
      end
      L_STEP: begin
        frac_q <= {frac_q[LOG_FRAC-2:0], t[63]};
        m_q    <= t[63] ? acc_q[125:63] : acc_q[124:62];
        it_q   <= it_q + 6'd1;
        k_q    <= '0;
        acc_q  <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == L_IDLE) && start_i && (x_i == '0)) ||
                 ((state_q == L_STEP) && (it_q == 6'(LOG_FRAC - 1)));
    end
  end

endmodule

`default_nettype wire

[rtl/spd_back.sv]
// ----------------------------------------------------------------------------
// spd_back
// Per-pair sequencer: fractions, uncorrected or corrected distance, status,
// and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_back #(
  parameter int unsigned CW = 17
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       job_valid_i,
  output logic                            job_pop_o,
  input  wire logic [CW-1:0]              job_sites_i,
  input  wire logic [CW-1:0]              job_ts_i,
  input  wire logic [CW-1:0]              job_tv_i,
  input  wire spd_pkg::mode_t             job_mode_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [spd_pkg::DIST_W-1:0]      distance_o,
  output logic [spd_pkg::FRAC_W-1:0]      transition_frac_o,
  output logic [spd_pkg::FRAC_W-1:0]      transversion_frac_o,
  output logic [spd_pkg::SITES_W-1:0]     sites_used_o,
  output logic [1:0]                      status_o
);
  import spd_pkg::*;

  localparam int unsigned XW = 2 * CW + 3;
  localparam int unsigned SW = (CW > SITES_W) ? CW : SITES_W;

  back_state_e           state_q, state_d;
  logic [CW-1:0]         e_q, p_q, q_q;
  mode_t                 mode_q;
  logic [QUO_W-1:0]      pf_q, qf_q;
  logic [DIST_W-1:0]     dist_q;
  status_e               st_q;
  logic [1:0]            sel_q;
  logic [2:0]            k_q;
  logic [XW-1:0]         big_q;
  logic signed [XW:0]    nn_q;
  logic [LOG_W-1:0]      la_q, lb_q, lc_q;
  logic [L2_W-1:0]       l2_q;
  logic [63:0]           mprod_q;
  logic [111:0]          macc_q;
  logic [31:0]           mul_a, mul_b;
  logic [XW:0]           five_prod;

  logic signed [CW+2:0]  xs, ys;
  logic                  div_start, div_done, log_start, log_done;
  logic [CW-1:0]         div_num;
  logic [QUO_W-1:0]      div_quo;
  logic [XW-1:0]         log_x;
  logic [LOG_W-1:0]      log_res, gap_b, gap_c;
  logic [48:0]           ln_r;

  logic                  out_valid_q;
  logic [DIST_W-1:0]     out_dist_q;
  logic [FRAC_W-1:0]     out_pf_q, out_qf_q;
  logic [SITES_W-1:0]    out_sites_q;
  status_e               out_st_q;
  logic [SW-1:0]         e_ext;
  logic                  load_out;

  assign xs = $signed({3'b000, e_q}) - $signed({2'b00, p_q, 1'b0}) - $signed({3'b000, q_q});
  assign ys = $signed({3'b000, e_q}) - $signed({2'b00, q_q, 1'b0});

  always_comb begin
    case (sel_q)
      2'd0:    div_num = p_q;
      2'd1:    div_num = q_q;
      default: div_num = p_q + q_q;
    endcase
    if (mode_q.dna_mode) begin
      case (sel_q)
        2'd0:    log_x = XW'(e_q);
        2'd1:    log_x = XW'(xs[CW-1:0]);
        default: log_x = XW'(ys[CW-1:0]);
      endcase
    end else begin
      log_x = (sel_q == 2'd0) ? big_q : nn_q[XW-1:0];
    end
  end

  always_comb begin
    mul_a = 32'(e_q);
    mul_b = 32'(e_q);
    if (state_q == S_PMUL) begin
      case (k_q)
        3'd1:    mul_a = 32'(p_q);
        3'd2: begin
          mul_a = 32'(p_q);
          mul_b = 32'(p_q);
        end
        default: ;
      endcase
    end else begin
      mul_a = (k_q == 3'd2 || k_q == 3'd3) ? 32'(l2_q[L2_W-1:32]) : l2_q[31:0];
      mul_b = (k_q == 3'd1 || k_q == 3'd3) ? LN2_Q64[63:32] : LN2_Q64[31:0];
    end
  end

  assign five_prod = (XW+1)'({mprod_q[2*CW-1:0], 2'b00}) + (XW+1)'(mprod_q[2*CW-1:0]);
  assign gap_b     = (la_q > lb_q) ? la_q - lb_q : '0;
  assign gap_c     = (la_q > lc_q) ? la_q - lc_q : '0;
  assign ln_r      = mode_q.dna_mode ?
                     (49'(macc_q[111:64]) + (49'd1 << 25)) >> 26 :
                     (49'(macc_q[111:64]) + (49'd1 << 23)) >> 24;
  assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    div_start = 1'b0;
    log_start = 1'b0;
    case (state_q)
      S_IDLE: if (job_valid_i) begin
        job_pop_o = 1'b1;
        state_d   = S_SETUP;
      end
      S_SETUP: state_d = (e_q == '0) ? S_DONE : S_DIV;
      S_DIV: begin
        div_start = k_q == 3'd0;
        if (div_done) begin
          if (sel_q == 2'd2) state_d = S_DONE;
          else if (sel_q == 2'd1 && mode_q.kimura_correct) state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (mode_q.dna_mode) state_d = (xs <= 0 || ys <= 0) ? S_DONE : S_LOG;
        else state_d = (p_q == '0) ? S_DONE : S_PMUL;
      end
      S_PMUL: if (k_q == 3'd3) state_d = S_PCHK;
      S_PCHK: state_d = (nn_q <= 0) ? S_DONE : S_LOG;
      S_LOG: begin
        log_start = k_q == 3'd0;
        if (log_done) begin
          if ((mode_q.dna_mode && sel_q == 2'd2) || (!mode_q.dna_mode && sel_q == 2'd1)) begin
            state_d = S_GAP;
          end
        end
      end
      S_GAP:   state_d = S_LN;
      S_LN:    if (k_q == 3'd4) state_d = S_LNFIN;
      S_LNFIN: state_d = S_DONE;
      S_DONE:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mprod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        e_q    <= job_sites_i;
        p_q    <= job_mode_i.dna_mode ? job_ts_i : job_ts_i + job_tv_i;
        q_q    <= job_mode_i.dna_mode ? job_tv_i : '0;
        mode_q <= job_mode_i;
      end
      S_SETUP: begin
        pf_q   <= '0;
        qf_q   <= '0;
        dist_q <= '0;
        st_q   <= (e_q == '0) ? ST_NO_SITES : ST_OK;
        sel_q  <= '0;
        k_q    <= '0;
      end
      S_DIV: begin
        if (div_done) begin
          k_q   <= '0;
          sel_q <= (sel_q == 2'd1 && mode_q.kimura_correct) ? 2'd0 : sel_q + 2'd1;
          case (sel_q)
            2'd0:    pf_q   <= div_quo;
            2'd1:    qf_q   <= div_quo;
            default: dist_q <= DIST_W'(div_quo);
          endcase
        end else begin
          k_q <= 3'd1;
        end
      end
      S_CHK: begin
        k_q <= '0;
        if (mode_q.dna_mode && (xs <= 0 || ys <= 0)) begin
          dist_q <= DIST_MAX;
          st_q   <= ST_UNDEF;
        end
      end
      S_PMUL: begin
        k_q <= k_q + 3'd1;
        case (k_q)
          3'd1: begin
            big_q <= five_prod[XW-1:0];
            nn_q  <= $signed(five_prod);
          end
          3'd2:    nn_q <= nn_q - $signed(five_prod);
          3'd3:    nn_q <= nn_q - $signed((XW+1)'(mprod_q[2*CW-1:0]));
          default: ;
        endcase
      end
      S_PCHK: begin
        k_q <= '0;
        if (nn_q <= 0) begin
          dist_q <= DIST_MAX;
          st_q   <= ST_UNDEF;
        end
      end
      S_LOG: begin
        if (log_done) begin
          k_q   <= '0;
          sel_q <= sel_q + 2'd1;
          case (sel_q)
            2'd0:    la_q <= log_res;
            2'd1:    lb_q <= log_res;
            default: lc_q <= log_res;
          endcase
        end else begin
          k_q <= 3'd1;
        end
      end
      S_GAP: begin
        k_q  <= '0;
        l2_q <= mode_q.dna_mode ? {1'b0, gap_b, 1'b0} + L2_W'(gap_c) : L2_W'(gap_b);
      end
      S_LN: begin
        k_q <= k_q + 3'd1;
        case (k_q)
          3'd1:    macc_q <= 112'(mprod_q);
          3'd2:    macc_q <= macc_q + (112'(mprod_q) << 32);
          3'd3:    macc_q <= macc_q + (112'(mprod_q) << 32);
          3'd4:    macc_q <= macc_q + (112'(mprod_q) << 64);
          default: ;
        endcase
      end
      S_LNFIN: dist_q <= (ln_r > 49'(DIST_MAX)) ? DIST_MAX : ln_r[DIST_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  spd_div #(
    .CW (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (e_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  spd_log2 #(
    .XW (XW)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .log_o   (log_res)
  );

  assign e_ext = SW'(e_q);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_dist_q  <= dist_q;
      out_pf_q    <= pf_q[FRAC_W-1:0];
      out_qf_q    <= mode_q.dna_mode ? qf_q[FRAC_W-1:0] : '0;
      out_sites_q <= (e_ext > SW'(SITES_OUT_MAX)) ? SITES_OUT_MAX : e_ext[SITES_W-1:0];
      out_st_q    <= st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign distance_o          = out_dist_q;
  assign transition_frac_o   = out_pf_q;
  assign transversion_frac_o = out_qf_q;
  assign sites_used_o        = out_sites_q;
  assign status_o            = out_st_q;

endmodule

`default_nettype wire

[rtl/sequence_pair_distance.sv]
// ----------------------------------------------------------------------------
// sequence_pair_distance
// Pairwise divergence of two aligned sequences, one column per transaction.
// Columns are taken one a cycle while the job queue has room; a two-entry job queue sits before the back end.
// Per pair the back end runs three divisions uncorrected; corrected, its time
// is set by the log2 unit (40 squarings per logarithm, two or three
// logarithms per pair).
// Reset: configuration returns to DNA mode, no correction, gap columns kept;
// counters and queue clear at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_pair_distance #(
  parameter int unsigned MAX_SITES = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic        cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // res_a[4:0], res_b[9:5], zero pad
  input  wire logic        s_axis_tuser_i,  // gap_column
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,  // distance, transition_frac,
                                            // transversion_frac, sites_used, pad
  output logic [1:0]       m_axis_tuser_o   // status
);
  import spd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SITES + 1);
  localparam int unsigned JW = 3 * CW + 2;

  logic              push, push_ready, pop, pop_valid;
  logic [CW-1:0]     f_sites, f_ts, f_tv, b_sites, b_ts, b_tv;
  mode_t             f_mode, b_mode;
  logic [JW-1:0]     push_data, pop_data;
  logic [DIST_W-1:0] distance;
  logic [FRAC_W-1:0] ts_frac, tv_frac;
  logic [SITES_W-1:0] sites_used;

  assign cfg_ready_o = 1'b1;

  spd_front #(
    .MAX_SITES (MAX_SITES),
    .CW        (CW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_addr_i   (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .col_valid_i  (s_axis_tvalid_i),
    .col_ready_o  (s_axis_tready_o),
    .res_a_i      (s_axis_tdata_i[4:0]),
    .res_b_i      (s_axis_tdata_i[9:5]),
    .gap_column_i (s_axis_tuser_i),
    .last_i       (s_axis_tlast_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .sites_o      (f_sites),
    .ts_o         (f_ts),
    .tv_o         (f_tv),
    .mode_o       (f_mode)
  );

  assign push_data = {f_mode, f_tv, f_ts, f_sites};

  spd_fifo #(
    .W (JW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  assign {b_mode, b_tv, b_ts, b_sites} = pop_data;

  spd_back #(
    .CW (CW)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .job_valid_i         (pop_valid),
    .job_pop_o           (pop),
    .job_sites_i         (b_sites),
    .job_ts_i            (b_ts),
    .job_tv_i            (b_tv),
    .job_mode_i          (b_mode),
    .out_valid_o         (m_axis_tvalid_o),
    .out_ready_i         (m_axis_tready_i),
    .distance_o          (distance),
    .transition_frac_o   (ts_frac),
    .transversion_frac_o (tv_frac),
    .sites_used_o        (sites_used),
    .status_o            (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {1'b0, sites_used, tv_frac, ts_frac, distance};

`ifndef ASSERT_OFF
  a_no_sites_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == ST_NO_SITES) |-> (m_axis_tdata_o == '0))
    else $error("no-site result carries non-zero data");

  a_undef_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == ST_UNDEF) |-> (distance == DIST_MAX))
    else $error("undefined correction without saturated distance");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3))
    else $error("result status out of range");

  a_ok_has_sites: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == ST_OK) |-> (sites_used != '0))
    else $error("ok status with no sites");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// sequence_pair_distance testbench
// Streams alignment columns through the block and checks each per-pair
// result against a predictor kept alongside the stimulus. The stimulus covers
// directed corner columns, random pairs under every register setting, one
// oversized pair, and random stalls on both stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spd_pkg::*;

  typedef struct {
    logic [4:0] res_a;
    logic [4:0] res_b;
    logic       gap_col;
    logic       last;
  } column_t;

  typedef struct {
    logic [19:0] distance;
    logic [16:0] ts_frac;
    logic [16:0] tv_frac;
    logic [16:0] sites;
    status_e     status;
  } pair_result_t;

  localparam int unsigned MAX_COLS  = 256;
  localparam int unsigned IDLE_LIM  = 20000;
  localparam int unsigned SETTLE    = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic        cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [71:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  sequence_pair_distance #(
    .MAX_SITES (MAX_COLS)
  ) dut (.*);

  column_t      column_queue[$];
  pair_result_t result_queue[$];

  logic        dna_on, kim_on, toss_on;
  logic [31:0] pair_sites, pair_ts, pair_tv;
  int          fail_count;
  int          pairs_checked;
  int          columns_sent;
  int          idle_cycles;
  logic        hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] log2_q40(input logic [63:0] x);
    logic [63:0]  t, m, frac;
    logic [127:0] sq;
    int           n;
    t = x; n = 0; frac = '0;
    if (x == 0) return '0;
    while (t > 1) begin
      t = t >> 1;
      n++;
    end
    m = x << (62 - n);
    for (int i = 0; i < 40; i++) begin
      sq = {64'd0, m} * {64'd0, m};
      m = sq[125:62];
      frac = frac << 1;
      if (m[63]) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(n) << 40) | frac;
  endfunction

  function automatic logic [63:0] log_ratio(input logic [63:0] big, input logic [63:0] sm);
    logic [63:0] la, lb;
    la = log2_q40(big);
    lb = log2_q40(sm);
    return la > lb ? la - lb : 64'd0;
  endfunction

  function automatic logic [19:0] ln_q16(input logic [63:0] l2, input int shift);
    logic [127:0] prod;
    logic [63:0]  r;
    int           s;
    s = 24 + shift;
    prod = {64'd0, l2} * {64'd0, LN2_Q64};
    r = (prod[127:64] + (64'd1 << (s - 1))) >> s;
    return r > 64'(DIST_MAX) ? DIST_MAX : r[19:0];
  endfunction

  function automatic logic [63:0] ratio_q16(input logic [63:0] num, input logic [63:0] den);
    return (2 * num * 65536 + den) / (2 * den);
  endfunction

  function automatic pair_result_t pair_divergence();
    pair_result_t r;
    logic [63:0]  e, p, q, dist_v, pf, qf;
    longint       x, y, big, n;
    e = pair_sites; dist_v = 0; pf = 0; qf = 0;
    r.status = ST_OK;
    if (dna_on) begin
      p = pair_ts; q = pair_tv;
    end else begin
      p = pair_ts + pair_tv; q = 0;
    end
    if (e == 0) begin
      r.status = ST_NO_SITES;
    end else begin
      pf = ratio_q16(p, e);
      qf = ratio_q16(q, e);
      if (!kim_on) begin
        dist_v = ratio_q16(p + q, e);
      end else if (dna_on) begin
        x = longint'(e) - 2 * longint'(p) - longint'(q);
        y = longint'(e) - 2 * longint'(q);
        if (x <= 0 || y <= 0) begin
          dist_v = DIST_MAX;
          r.status = ST_UNDEF;
        end else begin
          dist_v = ln_q16(2 * log_ratio(e, x) + log_ratio(e, y), 2);
        end
      end else if (p != 0) begin
        big = 5 * longint'(e) * longint'(e);
        n = big - 5 * longint'(p) * longint'(e) - longint'(p) * longint'(p);
        if (n <= 0) begin
          dist_v = DIST_MAX;
          r.status = ST_UNDEF;
        end else begin
          dist_v = ln_q16(log_ratio(big, n), 0);
        end
      end
    end
    if (dist_v > DIST_MAX) dist_v = DIST_MAX;
    r.distance = dist_v[19:0];
    r.ts_frac  = pf[16:0];
    r.tv_frac  = dna_on ? qf[16:0] : 17'd0;
    r.sites    = e > SITES_OUT_MAX ? SITES_OUT_MAX : e[16:0];
    return r;
  endfunction

  task automatic push_column(input logic [4:0] a, input logic [4:0] b,
                             input logic g, input logic l);
    column_t c;
    c.res_a = a; c.res_b = b; c.gap_col = g; c.last = l;
    column_queue.push_back(c);
    if (a != RES_GAP && b != RES_GAP && !(toss_on && g) && pair_sites < MAX_COLS) begin
      pair_sites++;
      if (a != b) begin
        if (!dna_on || is_transition(a, b)) pair_ts++;
        else pair_tv++;
      end
    end
    if (l) begin
      result_queue.push_back(pair_divergence());
      pair_sites = 0; pair_ts = 0; pair_tv = 0;
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DNA_MODE: dna_on  = val;
      CFG_KIMURA:   kim_on  = val;
      default:      toss_on = val;
    endcase
  endtask

  task automatic drain();
    while (column_queue.size() != 0 || result_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic random_pair(input int len, input int mis_pct, input logic close);
    logic [4:0] a, b;
    logic       g;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) begin
        a = 5'($urandom_range(31));
        b = 5'($urandom_range(31));
      end else begin
        a = $urandom_range(99) < 5 ? RES_GAP : 5'($urandom_range(4, 1));
        b = a;
        if (a != RES_GAP && $urandom_range(99) < mis_pct) begin
          if ($urandom_range(9) == 0) b = 5'($urandom_range(31, 5));
          else while (b == a) b = 5'($urandom_range(4, 1));
        end
        if ($urandom_range(99) < 4) b = RES_GAP;
      end
      g = $urandom_range(99) < 15;
      push_column(a, b, g, close && (i == len - 1));
      columns_sent++;
    end
  endtask

  // stream driver
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
      s_axis_tlast_i  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
      if (s_axis_tvalid_i) void'(column_queue.pop_front());
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(40, 1);
        gap_left   = $urandom_range(3) == 0 ? $urandom_range(6, 1) : 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (column_queue.size() != 0) begin
        burst_left--;
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {6'd0, column_queue[0].res_b, column_queue[0].res_a};
        s_axis_tuser_i  <= column_queue[0].gap_col;
        s_axis_tlast_i  <= column_queue[0].last;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // result receiver with its own stall pattern and one long hold-off
  int  stall_phase, hold_left;
  logic hold_taken;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_phase = 0;
      hold_left   = 0;
      hold_taken  = 1'b0;
    end else begin
      stall_phase++;
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if ((stall_phase / 500) % 3 == 0) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= $urandom_range(2) != 0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pair_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (result_queue.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata_o);
        fail_count++;
      end else begin
        exp_r = result_queue.pop_front();
        pairs_checked++;
        if (m_axis_tdata_o[19:0] !== exp_r.distance) begin
          $error("distance exp %0d got %0d", exp_r.distance, m_axis_tdata_o[19:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[36:20] !== exp_r.ts_frac) begin
          $error("transition_frac exp %0d got %0d", exp_r.ts_frac, m_axis_tdata_o[36:20]);
          fail_count++;
        end
        if (m_axis_tdata_o[53:37] !== exp_r.tv_frac) begin
          $error("transversion_frac exp %0d got %0d", exp_r.tv_frac,
                 m_axis_tdata_o[53:37]);
          fail_count++;
        end
        if (m_axis_tdata_o[70:54] !== exp_r.sites) begin
          $error("sites_used exp %0d got %0d", exp_r.sites, m_axis_tdata_o[70:54]);
          fail_count++;
        end
        if (m_axis_tuser_o !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, m_axis_tuser_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIM) begin
      $display("sequence_pair_distance regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    logic [2:0] mode;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_DNA_MODE;
    cfg_data_i  = 1'b0;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    dna_on = 1'b1; kim_on = 1'b0; toss_on = 1'b0;
    pair_sites = 0; pair_ts = 0; pair_tv = 0;
    fail_count = 0; pairs_checked = 0; columns_sent = 0; idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner columns under reset settings, then with correction and gap tossing, then outside DNA mode
    push_column(RES_GAP, RES_A, 1'b0, 1'b0);
    push_column(RES_T, RES_GAP, 1'b1, 1'b1);
    push_column(RES_A, RES_G, 1'b0, 1'b0);
    push_column(RES_G, RES_A, 1'b0, 1'b0);
    push_column(RES_C, RES_T, 1'b0, 1'b0);
    push_column(RES_T, RES_C, 1'b1, 1'b0);
    push_column(RES_A, RES_C, 1'b0, 1'b0);
    push_column(RES_A, 5'd31, 1'b0, 1'b0);
    push_column(5'd31, 5'd31, 1'b0, 1'b0);
    push_column(5'd10, 5'd21, 1'b0, 1'b1);
    drain();
    write_reg(CFG_KIMURA, 1'b1);
    write_reg(CFG_TOSS_GAP, 1'b1);
    push_column(RES_A, RES_G, 1'b0, 1'b0);
    push_column(RES_C, RES_T, 1'b0, 1'b0);
    push_column(RES_C, RES_G, 1'b1, 1'b1);
    push_column(RES_A, RES_A, 1'b0, 1'b0);
    push_column(RES_G, RES_G, 1'b0, 1'b1);
    push_column(RES_A, RES_T, 1'b0, 1'b0);
    push_column(RES_G, RES_C, 1'b0, 1'b1);
    drain();
    write_reg(CFG_DNA_MODE, 1'b0);
    push_column(RES_A, RES_A, 1'b0, 1'b1);
    push_column(RES_A, RES_C, 1'b0, 1'b1);
    push_column(RES_A, RES_A, 1'b0, 1'b0);
    push_column(5'd17, 5'd3, 1'b0, 1'b1);
    columns_sent = 21;
    drain();

    // oversized pair: counting stops at the site limit
    random_pair(MAX_COLS + 3, 40, 1'b1);
    drain();

    phase = 0;
    while (columns_sent < 1750) begin
      mode = phase < 8 ? 3'(phase) : 3'($urandom_range(7));
      if (mode[0] != dna_on)  write_reg(CFG_DNA_MODE, mode[0]);
      if (mode[1] != kim_on)  write_reg(CFG_KIMURA, mode[1]);
      if (mode[2] != toss_on) write_reg(CFG_TOSS_GAP, mode[2]);
      if (phase == 3) hold_req = 1'b1;
      for (int p = $urandom_range(8, 3); p > 0; p--) begin
        case ($urandom_range(3))
          0: random_pair($urandom_range(12, 1), 0, 1'b1);
          1: random_pair($urandom_range(12, 1), 15, 1'b1);
          2: random_pair($urandom_range(40, 1), 45, 1'b1);
          default: random_pair($urandom_range(6, 1), 100, 1'b1);
        endcase
      end
      // leave a pair open across the next register change now and then
      if ($urandom_range(4) == 0) random_pair($urandom_range(6, 1), 30, 1'b0);
      drain();
      phase++;
    end
    if (pair_sites != 0 || pair_ts != 0 || pair_tv != 0) begin
      random_pair(2, 30, 1'b1);
      drain();
    end

    $display("covered %0d columns over %0d register phases, %0d pair results checked",
             columns_sent, phase, pairs_checked);
    if (fail_count == 0) begin
      $display("sequence_pair_distance regression: pass");
    end else begin
      $display("sequence_pair_distance regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
